// ===== src/grtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grtr_pkg - shared types and constants of the glyph row text renderer
// Transaction structs, register codes, character codes and default sizes.
// ----------------------------------------------------------------------------
package grtr_pkg;

    localparam int COORD_W     = 12;
    localparam int MASK_W      = 8;
    localparam int COLOR_W     = 24;
    localparam int CODE_W      = 8;
    localparam int ROW_IN_W    = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // glyphs are eight pixels wide
    localparam int GLYPH_W = 8;

    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int LINE_PITCH_DEF  = 20;

    localparam logic [COORD_W-1:0] WRAP_LIMIT_RESET = 12'd1024;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 24'hFF_FFFF;

    localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam int                CHAR_SPACE     = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WRAP_LIMIT = 2'd0,
        REG_TEXT_COLOR = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        MODE_RENDER = 1'b0,
        MODE_LOAD   = 1'b1
    } mode_t;

    typedef struct packed {
        logic                mode;
        logic [CODE_W-1:0]   char_code;
        logic [ROW_IN_W-1:0] glyph_row;
        logic [MASK_W-1:0]   row_bits;
        logic                end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [MASK_W-1:0]  pixel_mask;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_row;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] wrap_limit;
        logic [COLOR_W-1:0] text_color;
    } cfg_regs_t;

endpackage

// ===== src/grtr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grtr_ram - generic single-clock RAM
// One write port, one read port, read data registered; holds while rd_en low.
// ----------------------------------------------------------------------------
module grtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/grtr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grtr_engine - glyph row sequencer
// Writes font rows, walks the glyph rows of a character through the font RAM,
// keeps the cursor and drives the registered result stage.
// ----------------------------------------------------------------------------
module grtr_engine
    import grtr_pkg::*;
#(
    parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int LINE_PITCH  = LINE_PITCH_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  in_item_t                                  s_data,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output out_item_t                                 m_data,
    input  cfg_regs_t                                 cfg,
    output logic                                      ram_wr_en,
    output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0] ram_wr_addr,
    output logic [MASK_W-1:0]                         ram_wr_data,
    output logic                                      ram_rd_en,
    output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0] ram_rd_addr,
    input  logic [MASK_W-1:0]                         ram_rd_data
);

    localparam int AW = $clog2(GLYPH_COUNT * GLYPH_ROWS);
    localparam int RW = $clog2(GLYPH_ROWS);
    localparam int GW = $clog2(GLYPH_COUNT);

    localparam logic [GW:0]   GLYPH_COUNT_W = (GW+1)'(GLYPH_COUNT);
    localparam logic [AW-1:0] ROWS_W        = AW'(GLYPH_ROWS);
    localparam logic [AW-1:0] SPACE_BASE    = AW'((CHAR_SPACE % GLYPH_COUNT) * GLYPH_ROWS);
    localparam logic [RW-1:0] ROW_LAST      = RW'(GLYPH_ROWS - 1);
    localparam logic [5:0]    ROWS_CMP      = 6'(GLYPH_ROWS);
    localparam logic [COORD_W-1:0] PITCH    = COORD_W'(LINE_PITCH);
    localparam logic [COORD_W-1:0] ADVANCE  = COORD_W'(GLYPH_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GLYPH,
        ST_SPACE
    } state_t;

    state_t             state_reg;
    logic [RW-1:0]      row_cnt_reg;
    logic               pend_reg;
    logic               m_valid_reg;
    logic [COORD_W-1:0] cursor_x_reg;
    logic [COORD_W-1:0] cursor_y_reg;
    logic [COORD_W-1:0] cursor_x_next;
    logic [COORD_W-1:0] cursor_y_next;

    logic [COORD_W-1:0] gx_reg;
    logic [COORD_W-1:0] bs_x_reg;
    logic [COORD_W-1:0] row_y_reg;
    logic [COORD_W-1:0] base_y_reg;
    logic               is_bs_reg;
    logic [AW-1:0]      glyph_base_reg;

    logic [COORD_W-1:0] pend_x_reg;
    logic [COORD_W-1:0] pend_y_reg;
    logic               pend_last_reg;

    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic               out_last_reg;

    logic               accept;
    logic               issue;
    logic               out_load;
    logic               row_last;
    logic [GW:0]        code_wide;
    logic [GW-1:0]      glyph_idx;
    logic [AW-1:0]      item_base;
    logic               row_ok;

    logic               is_nl;
    logic [COORD_W-1:0] adv_x;
    logic [COORD_W-1:0] line_x;
    logic [COORD_W-1:0] line_y;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = pend_reg && (!m_valid_reg || m_ready);
    assign issue    = (state_reg != ST_IDLE) && (!pend_reg || out_load);
    assign row_last = (row_cnt_reg == ROW_LAST);

    // glyph index is char_code modulo the glyph count; code never reaches twice it
    always_comb begin
        code_wide = (GW+1)'(s_data.char_code);
        glyph_idx = GW'((code_wide >= GLYPH_COUNT_W) ? code_wide - GLYPH_COUNT_W : code_wide);
        item_base = AW'(glyph_idx) * ROWS_W;
        row_ok    = {2'b00, s_data.glyph_row} < ROWS_CMP;
    end

    assign ram_wr_en   = accept && (s_data.mode == MODE_LOAD) && row_ok;
    assign ram_wr_addr = item_base + AW'(s_data.glyph_row);
    assign ram_wr_data = s_data.row_bits;
    assign ram_rd_en   = issue;
    assign ram_rd_addr = ((state_reg == ST_SPACE) ? SPACE_BASE : glyph_base_reg)
                         + AW'(row_cnt_reg);

    // cursor after a character: advance, newline, then end-of-text wrap
    always_comb begin
        is_nl  = (s_data.char_code == CHAR_NEWLINE);
        adv_x  = cursor_x_reg + ADVANCE;
        line_x = is_nl ? '0 : adv_x;
        line_y = is_nl ? cursor_y_reg + PITCH : cursor_y_reg;
        if (s_data.end_of_text && (line_x > cfg.wrap_limit)) begin
            cursor_x_next = '0;
            cursor_y_next = line_y + PITCH;
        end else begin
            cursor_x_next = line_x;
            cursor_y_next = line_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else begin
            if (accept) begin
                if (s_data.mode == MODE_RENDER) begin
                    state_reg    <= ST_GLYPH;
                    row_cnt_reg  <= '0;
                    cursor_x_reg <= cursor_x_next;
                    cursor_y_reg <= cursor_y_next;
                end
            end else if (issue) begin
                if (row_last) begin
                    row_cnt_reg <= '0;
                    state_reg   <= (state_reg == ST_GLYPH && is_bs_reg) ? ST_SPACE : ST_IDLE;
                end else begin
                    row_cnt_reg <= row_cnt_reg + 1'b1;
                end
            end

            if (issue) begin
                pend_reg <= 1'b1;
            end else if (out_load) begin
                pend_reg <= 1'b0;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (accept) begin
                gx_reg         <= cursor_x_reg;
                bs_x_reg       <= cursor_x_reg + COORD_W'(GLYPH_W - 1);
                row_y_reg      <= cursor_y_reg;
                base_y_reg     <= cursor_y_reg;
                is_bs_reg      <= (s_data.char_code == CHAR_BACKSPACE);
                glyph_base_reg <= item_base;
            end

            // metadata travels beside the read that is in flight
            if (issue) begin
                pend_x_reg    <= (state_reg == ST_SPACE) ? bs_x_reg : gx_reg;
                pend_y_reg    <= row_y_reg;
                pend_last_reg <= row_last && !(state_reg == ST_GLYPH && is_bs_reg);
                row_y_reg     <= row_last ? base_y_reg : row_y_reg + 1'b1;
            end

            if (out_load) begin
                out_x_reg    <= pend_x_reg;
                out_y_reg    <= pend_y_reg;
                out_mask_reg <= ram_rd_data;
                out_last_reg <= pend_last_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        m_data.pixel_x     = out_x_reg;
        m_data.pixel_y     = out_y_reg;
        m_data.pixel_mask  = out_mask_reg;
        m_data.pixel_color = cfg.text_color;
        m_data.last_row    = out_last_reg;
    end

`ifndef SYNTHESIS
    // read data waiting for the result stage must not be overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && !out_load |=> $stable(ram_rd_data))
        else $error("font read data lost while waiting for result stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> !ram_rd_en)
        else $error("font write overlaps a glyph row read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("result stage loaded without raising valid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.mode == MODE_RENDER) && !s_data.end_of_text
        && (s_data.char_code != CHAR_NEWLINE)
        |=> cursor_x_reg == $past(cursor_x_reg) + ADVANCE)
        else $error("cursor failed to advance by one glyph");
`endif

endmodule

// ===== src/glyph_row_text_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_text_renderer - 8-pixel-wide bitmap font character generator
// Loads font rows into a RAM and renders characters as glyph row masks.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      in_item_t  (load or character)
//   m_       out        m_valid / m_ready      out_item_t (one glyph row)
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load is one RAM write. A character makes GLYPH_ROWS reads of the single
// font RAM read port, one row per cycle unless the result stage stalls;
// a backspace reads 2 * GLYPH_ROWS rows. The next item enters once
// the last row read has been issued. A stalled m_ready holds the RAM read
// data and the row sequence. Reset clears cursor and registers; the font RAM
// is not cleared and every glyph row must be loaded before it is rendered.
// ----------------------------------------------------------------------------
module glyph_row_text_renderer
    import grtr_pkg::*;
#(
    parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int LINE_PITCH  = LINE_PITCH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);

    cfg_regs_t        cfg_reg;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [MASK_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [MASK_W-1:0] ram_rd_data;

    assign cfg_ready = 1'b1;

    // register file; writes to unknown indices are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_limit <= WRAP_LIMIT_RESET;
            cfg_reg.text_color <= TEXT_COLOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WRAP_LIMIT: begin
                    cfg_reg.wrap_limit <= cfg_data[COORD_W-1:0];
                end
                REG_TEXT_COLOR: begin
                    cfg_reg.text_color <= cfg_data[COLOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    grtr_ram #(
        .WIDTH (MASK_W),
        .DEPTH (DEPTH)
    ) u_font_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    grtr_engine #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT),
        .LINE_PITCH  (LINE_PITCH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg         (cfg_reg),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the glyph row text renderer
// Loads glyphs into the font store, renders text and checks every glyph row
// against a transaction-level model of the cursor, font store and registers,
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import grtr_pkg::*;

    localparam int FONT_DEPTH   = GLYPH_ROWS_DEF * GLYPH_COUNT_DEF;
    localparam int SETTLE_WAIT  = 2 * GLYPH_ROWS_DEF + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 72;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_WRAP_LIMIT;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // font store, cursor and register copies of the renderer
    logic [MASK_W-1:0]  font_rows [FONT_DEPTH];
    bit                 row_written [FONT_DEPTH];
    bit                 glyph_listed [GLYPH_COUNT_DEF];
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    logic [COORD_W-1:0] width_reg;
    logic [COLOR_W-1:0] color_reg;

    out_item_t          expected_rows [$];
    logic [CODE_W-1:0]  ready_glyphs [$];

    int error_count  = 0;
    int items_sent   = 0;
    int rows_checked = 0;
    int cycle_count  = 0;
    int tx_max_gap   = 0;
    int tx_max_burst = 1;
    int burst_left   = 0;
    int rx_stall_pct = 0;
    int rx_max_stall = 1;
    int stall_left   = 0;

    glyph_row_text_renderer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d rows outstanding",
                     cycle_count, expected_rows.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: stall for random stretches at a rate set per phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(rx_max_stall - 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH %s", $time, what);
        error_count++;
    endtask

    always @(posedge aclk) begin : row_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected row x=%0d y=%0d mask=%h",
                                          m_data.pixel_x, m_data.pixel_y,
                                          m_data.pixel_mask));
            end else begin
                want = expected_rows.pop_front();
                if (m_data.pixel_x !== want.pixel_x)
                    report_mismatch($sformatf("row %0d pixel_x got %0d want %0d",
                                              rows_checked, m_data.pixel_x, want.pixel_x));
                if (m_data.pixel_y !== want.pixel_y)
                    report_mismatch($sformatf("row %0d pixel_y got %0d want %0d",
                                              rows_checked, m_data.pixel_y, want.pixel_y));
                if (m_data.pixel_mask !== want.pixel_mask)
                    report_mismatch($sformatf("row %0d pixel_mask got %h want %h",
                                              rows_checked, m_data.pixel_mask,
                                              want.pixel_mask));
                if (m_data.pixel_color !== want.pixel_color)
                    report_mismatch($sformatf("row %0d pixel_color got %h want %h",
                                              rows_checked, m_data.pixel_color,
                                              want.pixel_color));
                if (m_data.last_row !== want.last_row)
                    report_mismatch($sformatf("row %0d last_row got %b want %b",
                                              rows_checked, m_data.last_row, want.last_row));
                rows_checked++;
            end
        end
    end

    function automatic bit glyph_complete(logic [CODE_W-1:0] code);
        for (int r = 0; r < GLYPH_ROWS_DEF; r++)
            if (!row_written[int'(code) * GLYPH_ROWS_DEF + r])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_glyph_rows(logic [CODE_W-1:0] code, logic [COORD_W-1:0] x,
                                            logic [COORD_W-1:0] y, bit closes_item);
        out_item_t row;
        for (int r = 0; r < GLYPH_ROWS_DEF; r++) begin
            row.pixel_x     = x;
            row.pixel_y     = y + COORD_W'(r);
            row.pixel_mask  = font_rows[int'(code) * GLYPH_ROWS_DEF + r];
            row.pixel_color = color_reg;
            row.last_row    = closes_item && (r == GLYPH_ROWS_DEF - 1);
            expected_rows.push_back(row);
        end
    endfunction

    function automatic void predict_glyph_rows(in_item_t it);
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        int                 addr;
        addr = int'(it.char_code) * GLYPH_ROWS_DEF + int'(it.glyph_row);
        if (it.mode == MODE_LOAD) begin
            font_rows[addr]   = it.row_bits;
            row_written[addr] = 1'b1;
            if (!glyph_listed[it.char_code] && glyph_complete(it.char_code)) begin
                glyph_listed[it.char_code] = 1'b1;
                ready_glyphs.push_back(it.char_code);
            end
        end else begin
            push_glyph_rows(it.char_code, pen_x, pen_y, it.char_code != CHAR_BACKSPACE);
            nx = pen_x + COORD_W'(GLYPH_W);
            ny = pen_y;
            if (it.char_code == CHAR_NEWLINE) begin
                nx = '0;
                ny = pen_y + COORD_W'(LINE_PITCH_DEF);
            end
            // rub out with a space one pixel left of the advanced cursor
            if (it.char_code == CHAR_BACKSPACE)
                push_glyph_rows(CODE_W'(CHAR_SPACE), nx - COORD_W'(1), ny, 1'b1);
            if (it.end_of_text && nx > width_reg) begin
                nx = '0;
                ny = ny + COORD_W'(LINE_PITCH_DEF);
            end
            pen_x = nx;
            pen_y = ny;
        end
    endfunction

    function automatic in_item_t load_item(logic [CODE_W-1:0] code, logic [ROW_IN_W-1:0] row,
                                           logic [MASK_W-1:0] bits);
        in_item_t it;
        it.mode        = MODE_LOAD;
        it.char_code   = code;
        it.glyph_row   = row;
        it.row_bits    = bits;
        it.end_of_text = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t char_item(logic [CODE_W-1:0] code, logic eot);
        in_item_t it;
        it.mode        = MODE_RENDER;
        it.char_code   = code;
        it.glyph_row   = ROW_IN_W'($urandom);
        it.row_bits    = MASK_W'($urandom);
        it.end_of_text = eot;
        return it;
    endfunction

    task automatic set_idling(int max_gap, int max_burst, int stall_pct, int max_stall);
        tx_max_gap   = max_gap;
        tx_max_burst = max_burst;
        rx_stall_pct = stall_pct;
        rx_max_stall = max_stall;
        burst_left   = 0;
    endtask

    task automatic send_item(in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_glyph_rows(it);
        items_sent++;
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(tx_max_burst, 1);
            gap        = $urandom_range(tx_max_gap);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // hold off until every row has come, then let a load or read settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_WRAP_LIMIT)
            width_reg = value[COORD_W-1:0];
        else
            color_reg = value[COLOR_W-1:0];
        @(posedge aclk);
    endtask

    task automatic set_config(logic [COORD_W-1:0] width, logic [COLOR_W-1:0] color);
        wait_idle();
        // upper data bits beyond the width register are junk
        write_reg(REG_WRAP_LIMIT, {COORD_W'($urandom), width});
        write_reg(REG_TEXT_COLOR, color);
    endtask

    // fill < 0 gives random rows; rows go in a scrambled order
    task automatic load_glyph(logic [CODE_W-1:0] code, int fill);
        int start;
        int stride;
        start  = $urandom_range(GLYPH_ROWS_DEF - 1);
        stride = 2 * $urandom_range(GLYPH_ROWS_DEF / 2 - 1) + 1;
        for (int k = 0; k < GLYPH_ROWS_DEF; k++)
            send_item(load_item(code, ROW_IN_W'(start + k * stride),
                                (fill < 0) ? MASK_W'($urandom) : MASK_W'(fill)));
    endtask

    task automatic test_font_preload();
        set_idling(3, 6, 20, 4);
        load_glyph(8'd0, 8'h00);
        load_glyph(8'd255, 8'hFF);
        load_glyph(CHAR_BACKSPACE, -1);
        load_glyph(CHAR_NEWLINE, -1);
        load_glyph(CODE_W'(CHAR_SPACE), -1);
        load_glyph(8'd65, -1);
        load_glyph(8'd128, -1);
    endtask

    task automatic test_directed_render();
        set_idling(2, 3, 25, 6);
        send_item(char_item(8'd65, 1'b0));
        send_item(char_item(8'd0, 1'b0));
        send_item(char_item(8'd255, 1'b0));
        send_item(char_item(8'd128, 1'b1));
        send_item(char_item(CHAR_BACKSPACE, 1'b0));
        send_item(char_item(CHAR_NEWLINE, 1'b0));
        send_item(char_item(CHAR_NEWLINE, 1'b1));
        send_item(char_item(8'd65, 1'b1));
        // zero width: every end of text past x = 0 wraps
        set_config(12'd0, 24'h000000);
        send_item(char_item(8'd65, 1'b1));
        send_item(char_item(CHAR_BACKSPACE, 1'b1));
        send_item(char_item(CHAR_NEWLINE, 1'b1));
        send_item(char_item(8'd255, 1'b0));
        // cursor exactly at the width does not wrap, one glyph further does
        set_config(12'd8, 24'h5A_A5C3);
        send_item(char_item(CHAR_NEWLINE, 1'b0));
        send_item(char_item(8'd65, 1'b1));
        send_item(char_item(8'd0, 1'b1));
        set_config(12'd4095, 24'hFF_FFFF);
        send_item(char_item(8'd128, 1'b1));
        send_item(char_item(CHAR_BACKSPACE, 1'b1));
        send_item(char_item(8'd65, 1'b1));
    endtask

    task automatic test_random_text();
        int                sent;
        int                pick;
        logic [CODE_W-1:0] code;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    set_idling(0, 1, 0, 1);
                    set_config(COORD_W'($urandom_range(160, 16)), COLOR_W'($urandom));
                end
                1: begin
                    set_idling(8, 3, 35, 10);
                    set_config(12'd0, 24'h000000);
                end
                2: begin
                    set_idling(2, 12, 10, 4);
                    set_config(12'd4095, 24'hFF_FFFF);
                end
                default: begin
                    set_idling(12, 2, 50, 10);
                    set_config(COORD_W'($urandom), COLOR_W'($urandom));
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    load_glyph(CODE_W'($urandom), -1);
                    sent += GLYPH_ROWS_DEF;
                end else if (pick < 16) begin
                    send_item(load_item(CODE_W'($urandom), ROW_IN_W'($urandom),
                                        MASK_W'($urandom)));
                    sent++;
                end else begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        code = CHAR_NEWLINE;
                    else if (pick == 1)
                        code = CHAR_BACKSPACE;
                    else
                        code = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
                    send_item(char_item(code, $urandom_range(3) == 0));
                    sent++;
                end
                if ($urandom_range(99) == 0)
                    wait_idle();
            end
        end
    endtask

    initial begin
        pen_x     = '0;
        pen_y     = '0;
        width_reg = WRAP_LIMIT_RESET;
        color_reg = TEXT_COLOR_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_font_preload();
        test_directed_render();
        test_random_text();
        wait_idle();
        $display("Sent %0d load and character transactions, checked %0d glyph rows",
                 items_sent, rows_checked);
        $display("Exercised backspace, newline, end-of-text wrap "
                 , "and register extremes under random gaps and stalls");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/grtr_pkg.sv
src/grtr_ram.sv
src/grtr_engine.sv
src/glyph_row_text_renderer.sv
tb/tb_top.sv
